/* sv/lbh_pkg.sv */
// Shared types, constants and round functions for the byte hash unit.
package lbh_pkg;

    localparam int          MAX_KEY_LENGTH    = 256;
    localparam int          LEN_W             = 9;
    localparam int          POS_W             = 4;
    localparam int          BLOCK_BYTES       = 12;
    localparam int          MIX_LINES         = 6;
    localparam int          FINAL_LINES       = 7;
    localparam logic [31:0] SEED_BASE         = 32'hdeadbeef;
    localparam logic [31:0] HASH_MASK         = 32'h0000_7fff;
    localparam logic [31:0] INIT_VALUE_RESET  = 32'd146;
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(BLOCK_BYTES - 1);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_hash_state;

    typedef struct packed {
        logic        vld;
        t_hash_state st;
    } t_mix_job;

    typedef struct packed {
        logic        vld;
        logic        bypass;
        t_hash_state st;
    } t_fin_job;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
        logic [63:0] t;
        t = {x, x} << k;
        return t[63:32];
    endfunction

    function automatic t_hash_state mix_line(input logic [2:0] idx, input t_hash_state v);
        t_hash_state r;
        r = v;
        case (idx)
            3'd0: begin r.a = (v.a - v.c) ^ rotl(v.c, 5'd4);  r.c = v.c + v.b; end
            3'd1: begin r.b = (v.b - v.a) ^ rotl(v.a, 5'd6);  r.a = v.a + v.c; end
            3'd2: begin r.c = (v.c - v.b) ^ rotl(v.b, 5'd8);  r.b = v.b + v.a; end
            3'd3: begin r.a = (v.a - v.c) ^ rotl(v.c, 5'd16); r.c = v.c + v.b; end
            3'd4: begin r.b = (v.b - v.a) ^ rotl(v.a, 5'd19); r.a = v.a + v.c; end
            3'd5: begin r.c = (v.c - v.b) ^ rotl(v.b, 5'd4);  r.b = v.b + v.a; end
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic t_hash_state final_line(input logic [2:0] idx, input t_hash_state v);
        t_hash_state r;
        r = v;
        case (idx)
            3'd0: r.c = (v.c ^ v.b) - rotl(v.b, 5'd14);
            3'd1: r.a = (v.a ^ v.c) - rotl(v.c, 5'd11);
            3'd2: r.b = (v.b ^ v.a) - rotl(v.a, 5'd25);
            3'd3: r.c = (v.c ^ v.b) - rotl(v.b, 5'd16);
            3'd4: r.a = (v.a ^ v.c) - rotl(v.c, 5'd4);
            3'd5: r.b = (v.b ^ v.a) - rotl(v.a, 5'd14);
            3'd6: r.c = (v.c ^ v.b) - rotl(v.b, 5'd24);
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

/* sv/lookup3_byte_hash_unit.sv */
// Top level of the streaming lookup3 little-endian byte hash unit.
// Takes one key byte per cycle while o_stall is low; a result becomes valid once the final
// pipeline has taken a key's last byte (or a zero-length key); results can leave one per cycle while i_stall is low.
// A full 12-byte block feeds a 6-stage mix pipeline whose state returns to the front end;
// a block-ending or key-ending byte arriving before that is held off until it returns.
// Synchronous active-low reset clears valid, length, position and base state, sets initial_value to 146.
module lookup3_byte_hash_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_key_byte,
    input  logic [lbh_pkg::LEN_W-1:0] i_key_length,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [31:0]               o_hash_value,
    input  logic                      i_cfg_we,
    input  logic [31:0]               i_cfg_wdata
);
    logic                 adv;
    logic                 mix_busy;
    logic                 mix_done;
    lbh_pkg::t_hash_state mix_result;
    lbh_pkg::t_mix_job    mix_job;
    lbh_pkg::t_fin_job    fin_job;

    lbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_byte   (i_key_byte),
        .i_key_length (i_key_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_adv        (adv),
        .i_mix_busy   (mix_busy),
        .i_mix_done   (mix_done),
        .i_mix_result (mix_result),
        .o_mix_job    (mix_job),
        .o_fin_job    (fin_job)
    );

    lbh_mix_pipe u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (mix_job),
        .o_busy   (mix_busy),
        .o_done   (mix_done),
        .o_result (mix_result)
    );

    lbh_final_pipe u_fin (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (fin_job),
        .o_adv        (adv),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

/* sv/lbh_mix_pipe.sv */
// Mix round pipeline: one mix line per stage, result written back to the front end.
module lbh_mix_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbh_pkg::t_mix_job    i_job,
    output logic                 o_busy,
    output logic                 o_done,
    output lbh_pkg::t_hash_state o_result
);
    localparam int N = lbh_pkg::MIX_LINES;

    logic [N:0]           r_vld;
    lbh_pkg::t_hash_state r_st [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_job.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= i_job.st;
        for (int s = 1; s <= N; s++) begin
            r_st[s] <= lbh_pkg::mix_line(3'(s - 1), r_st[s-1]);
        end
    end

    assign o_busy   = |r_vld;
    assign o_done   = r_vld[N];
    assign o_result = r_st[N];

endmodule

/* sv/lbh_final_pipe.sv */
// Final round pipeline with output register and stall handling.
module lbh_final_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbh_pkg::t_fin_job i_job,
    output logic              o_adv,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_hash_value
);
    localparam int N = lbh_pkg::FINAL_LINES;

    logic [N:0]           r_vld;
    logic [N:0]           r_byp;
    lbh_pkg::t_hash_state r_st [N+1];

    assign o_adv = !(r_vld[N] && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (o_adv) begin
            r_vld <= {r_vld[N-1:0], i_job.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_byp[0] <= i_job.bypass;
            r_st[0]  <= i_job.st;
            for (int s = 1; s <= N; s++) begin
                r_byp[s] <= r_byp[s-1];
                r_st[s]  <= r_byp[s-1] ? r_st[s-1]
                                       : lbh_pkg::final_line(3'(s - 1), r_st[s-1]);
            end
        end
    end

    assign o_valid      = r_vld[N];
    assign o_hash_value = r_byp[N] ? r_st[N].c : (r_st[N].c & lbh_pkg::HASH_MASK);

endmodule

/* sv/lbh_front.sv */
// Front end: key sequencing, byte lanes, base state and job issue.
module lbh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_key_byte,
    input  logic [lbh_pkg::LEN_W-1:0]    i_key_length,
    input  logic                         i_cfg_we,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic                         i_adv,
    input  logic                         i_mix_busy,
    input  logic                         i_mix_done,
    input  lbh_pkg::t_hash_state         i_mix_result,
    output lbh_pkg::t_mix_job            o_mix_job,
    output lbh_pkg::t_fin_job            o_fin_job
);
    localparam int LW = lbh_pkg::LEN_W;
    localparam int PW = lbh_pkg::POS_W;
    localparam int NB = lbh_pkg::BLOCK_BYTES;

    logic [31:0]          r_init;
    logic [LW-1:0]        r_left;
    logic [PW-1:0]        r_pos;
    logic [7:0]           r_k [NB];
    lbh_pkg::t_hash_state r_base;

    logic                 new_key;
    logic [LW-1:0]        len_sat;
    logic [31:0]          seed;
    logic [PW-1:0]        pos;
    logic [LW-1:0]        left_now;
    logic                 zero_key;
    logic                 last;
    logic                 blk_end;
    logic                 accept;
    logic [7:0]           k_cur [NB];
    lbh_pkg::t_hash_state base;
    lbh_pkg::t_hash_state sum;
    logic [LW-1:0]        n_left;
    logic [PW-1:0]        n_pos;

    always_comb begin
        new_key  = (r_left == '0);
        len_sat  = (32'(i_key_length) > 32'(lbh_pkg::MAX_KEY_LENGTH))
                   ? LW'(lbh_pkg::MAX_KEY_LENGTH) : i_key_length;
        seed     = lbh_pkg::SEED_BASE + 32'(len_sat) + r_init;
        pos      = new_key ? '0 : ((r_pos > lbh_pkg::LAST_POS) ? lbh_pkg::LAST_POS : r_pos);
        left_now = new_key ? len_sat : r_left;
        zero_key = new_key && (len_sat == '0);
        last     = !zero_key && (left_now == LW'(1));
        blk_end  = !zero_key && !last && (pos == lbh_pkg::LAST_POS);
        base     = new_key ? '{a: seed, b: seed, c: seed} : r_base;
        for (int j = 0; j < NB; j++) begin
            if (PW'(j) < pos) begin
                k_cur[j] = r_k[j];
            end else if (PW'(j) == pos) begin
                k_cur[j] = i_key_byte;
            end else begin
                k_cur[j] = '0;
            end
        end
        sum.a = base.a + {k_cur[3], k_cur[2], k_cur[1], k_cur[0]};
        sum.b = base.b + {k_cur[7], k_cur[6], k_cur[5], k_cur[4]};
        sum.c = base.c + {k_cur[11], k_cur[10], k_cur[9], k_cur[8]};
        n_left = left_now - LW'(1);
        n_pos  = (last || blk_end) ? '0 : pos + PW'(1);
    end

    assign o_stall = !i_adv
                   || (i_mix_busy && ((r_left == LW'(1)) || (r_pos >= lbh_pkg::LAST_POS)));
    assign accept  = i_valid && !o_stall;

    assign o_mix_job.vld = accept && blk_end;
    assign o_mix_job.st  = sum;

    assign o_fin_job.vld    = accept && (zero_key || last);
    assign o_fin_job.bypass = zero_key;
    assign o_fin_job.st     = zero_key ? base : sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= lbh_pkg::INIT_VALUE_RESET;
            r_left <= '0;
            r_pos  <= '0;
            r_base <= '0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            if (i_mix_done) begin
                r_base <= i_mix_result;
            end
            if (accept && !zero_key) begin
                if (new_key) begin
                    r_base <= base;
                end
                r_left <= n_left;
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !zero_key) begin
            r_k[pos] <= i_key_byte;
        end
    end

endmodule

/* bench/tb_lookup3_byte_hash_unit.sv */
// Self-checking testbench for the streaming lookup3 byte hash unit.
`timescale 1ns / 100ps

module tb_lookup3_byte_hash_unit;
    localparam int LW = lbh_pkg::LEN_W;
    localparam int PW = lbh_pkg::POS_W;

    typedef struct packed {
        logic [LW-1:0] len;
        logic [7:0]    first;
        logic [7:0]    step;
        logic          lit_ok;
        logic [31:0]   lit;
    } t_key_row;

    localparam t_key_row DIRECTED_KEYS [11] = '{
        '{9'd0,   8'hff, 8'h00, 1'b1, 32'hdeadbf81},
        '{9'd0,   8'h00, 8'h00, 1'b1, 32'hdeadbf81},
        '{9'd1,   8'h00, 8'h00, 1'b0, 32'h0},
        '{9'd1,   8'hff, 8'h00, 1'b0, 32'h0},
        '{9'd4,   8'h80, 8'h01, 1'b0, 32'h0},
        '{9'd11,  8'h01, 8'h01, 1'b0, 32'h0},
        '{9'd12,  8'hff, 8'h00, 1'b0, 32'h0},
        '{9'd13,  8'ha5, 8'h5a, 1'b0, 32'h0},
        '{9'd24,  8'h00, 8'h11, 1'b0, 32'h0},
        '{9'd25,  8'h7f, 8'h03, 1'b0, 32'h0},
        '{9'd511, 8'hff, 8'h00, 1'b0, 32'h0}
    };

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          i_valid      = 1'b0;
    logic          o_stall;
    logic [7:0]    i_key_byte   = 8'h00;
    logic [LW-1:0] i_key_length = '0;
    logic          o_valid;
    logic          i_stall      = 1'b0;
    logic [31:0]   o_hash_value;
    logic          i_cfg_we     = 1'b0;
    logic [31:0]   i_cfg_wdata  = 32'h0;

    logic [31:0]   hash_a = '0;
    logic [31:0]   hash_b = '0;
    logic [31:0]   hash_c = '0;
    logic [31:0]   seed_init = lbh_pkg::INIT_VALUE_RESET;
    logic [LW-1:0] bytes_left = '0;
    logic [PW-1:0] block_pos = '0;

    logic [31:0]   expected_hashes [$];
    logic [31:0]   want_hash;
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            burst_left = 0;
    bit            gaps_on = 1'b0;
    int            hold_left = 0;
    logic [31:0]   rx_cycle = '0;

    lookup3_byte_hash_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_byte   (i_key_byte),
        .i_key_length (i_key_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] rot32(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic void stir_block();
        logic [31:0] a, b, c;
        a = hash_a; b = hash_b; c = hash_c;
        a -= c; a ^= rot32(c, 4);  c += b;
        b -= a; b ^= rot32(a, 6);  a += c;
        c -= b; c ^= rot32(b, 8);  b += a;
        a -= c; a ^= rot32(c, 16); c += b;
        b -= a; b ^= rot32(a, 19); a += c;
        c -= b; c ^= rot32(b, 4);  b += a;
        hash_a = a; hash_b = b; hash_c = c;
    endfunction

    function automatic void finish_hash();
        logic [31:0] a, b, c;
        a = hash_a; b = hash_b; c = hash_c;
        c ^= b; c -= rot32(b, 14);
        a ^= c; a -= rot32(c, 11);
        b ^= a; b -= rot32(a, 25);
        c ^= b; c -= rot32(b, 16);
        a ^= c; a -= rot32(c, 4);
        b ^= a; b -= rot32(a, 14);
        c ^= b; c -= rot32(b, 24);
        hash_a = a; hash_b = b; hash_c = c;
    endfunction

    function automatic bit absorb_byte(input logic [7:0] kb, input logic [LW-1:0] kl,
                                       output logic [31:0] hash);
        logic [LW-1:0] n;
        logic [31:0]   seed;
        logic [31:0]   lane;
        logic [PW-1:0] p;
        hash = '0;
        if (bytes_left == 0) begin
            n = (kl > lbh_pkg::MAX_KEY_LENGTH) ? LW'(lbh_pkg::MAX_KEY_LENGTH) : kl;
            seed = lbh_pkg::SEED_BASE + 32'(n) + seed_init;
            hash_a = seed;
            hash_b = seed;
            hash_c = seed;
            block_pos = '0;
            if (n == 0) begin
                hash = seed;
                return 1'b1;
            end
            bytes_left = n;
        end
        p = block_pos;
        lane = 32'(kb) << (8 * p[1:0]);
        if (p < 4)
            hash_a += lane;
        else if (p < 8)
            hash_b += lane;
        else
            hash_c += lane;
        bytes_left = bytes_left - 1'b1;
        p = p + 1'b1;
        if (bytes_left == 0) begin
            finish_hash();
            block_pos = '0;
            hash = hash_c & lbh_pkg::HASH_MASK;
            return 1'b1;
        end
        if (p == lbh_pkg::BLOCK_BYTES) begin
            stir_block();
            p = '0;
        end
        block_pos = p;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t %s: got %h want %h", $time, what, got, want);
    endtask

    task automatic send_item(input logic [7:0] kb, input logic [LW-1:0] kl,
                             input bit use_lit, input logic [31:0] lit);
        logic [31:0] h;
        i_valid <= 1'b1;
        i_key_byte <= kb;
        i_key_length <= kl;
        do @(posedge i_clk); while (o_stall);
        if (absorb_byte(kb, kl, h))
            expected_hashes.push_back(use_lit ? lit : h);
        items_sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                burst_left = $urandom_range(0, 20);
            end
        end
    endtask

    task automatic send_key(input logic [LW-1:0] len_field, input bit rand_bytes,
                            input logic [7:0] first, input logic [7:0] step,
                            input bit use_lit, input logic [31:0] lit);
        int          n;
        logic [7:0]  kb;
        n = (len_field > lbh_pkg::MAX_KEY_LENGTH) ? lbh_pkg::MAX_KEY_LENGTH : int'(len_field);
        if (n == 0)
            n = 1;
        for (int i = 0; i < n; i++) begin
            kb = rand_bytes ? 8'($urandom) : 8'(first + i * step);
            send_item(kb, (i == 0) ? len_field : LW'($urandom), use_lit, lit);
        end
    endtask

    task automatic run_random(input int count);
        int            stop;
        int            r;
        logic [LW-1:0] len;
        stop = items_sent + count;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 12)
                len = '0;
            else if (r < 80)
                len = LW'($urandom_range(1, 26));
            else if (r < 99)
                len = LW'($urandom_range(27, 60));
            else
                len = LW'($urandom_range(100, 511));
            send_key(len, 1'b1, 8'h00, 8'h00, 1'b0, 32'h0);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_hashes.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        seed_init = value;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            case (rx_cycle[8:7])
                2'd0: i_stall <= 1'b0;
                2'd1: i_stall <= ($urandom_range(0, 99) < 30);
                2'd2: i_stall <= ($urandom_range(0, 99) < 75);
                default: i_stall <= rx_cycle[1];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hashes.size() == 0) begin
                report_mismatch("unexpected hash transfer", o_hash_value, 32'hx);
            end else begin
                want_hash = expected_hashes.pop_front();
                if (o_hash_value !== want_hash)
                    report_mismatch("hash_value mismatch", o_hash_value, want_hash);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL lookup3_byte_hash_unit");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on = 1'b1;
        foreach (DIRECTED_KEYS[k])
            send_key(DIRECTED_KEYS[k].len, 1'b0, DIRECTED_KEYS[k].first,
                     DIRECTED_KEYS[k].step, DIRECTED_KEYS[k].lit_ok, DIRECTED_KEYS[k].lit);
        settle();

        write_seed(32'h0000_0000);
        run_random(40);
        settle();

        // hold the output long enough to back the block up
        write_seed(32'hffff_ffff);
        gaps_on = 1'b0;
        hold_left = 300;
        run_random(40);
        settle();

        // change the seed in the middle of a key
        gaps_on = 1'b1;
        for (int i = 0; i < 17; i++)
            send_item(8'($urandom), (i == 0) ? LW'(30) : LW'($urandom), 1'b0, 32'h0);
        settle();
        write_seed($urandom);
        for (int i = 0; i < 13; i++)
            send_item(8'($urandom), LW'($urandom), 1'b0, 32'h0);
        settle();

        write_seed($urandom);
        run_random(30);
        settle();

        write_seed($urandom);
        gaps_on = 1'b0;
        run_random(20);
        settle();

        if (mismatch_count == 0)
            $display("PASS lookup3_byte_hash_unit");
        else
            $display("FAIL lookup3_byte_hash_unit");
        $finish;
    end

endmodule

/* files.f */
sv/lbh_pkg.sv
sv/lbh_mix_pipe.sv
sv/lbh_final_pipe.sv
sv/lbh_front.sv
sv/lookup3_byte_hash_unit.sv
bench/tb_lookup3_byte_hash_unit.sv
